// File: rtl/prefix_expression_evaluator_macros.svh
// Assertion helpers, sampled on clk_i and held off while rst_ni is low.
`ifndef PREFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define PREFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication.
`define PFXEV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfxev assertion failed");

// Next-cycle implication.
`define PFXEV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfxev assertion failed");

`endif

// File: rtl/pfxev_pkg.sv
`timescale 1ns / 1ps

package pfxev_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;

  typedef struct packed {
    logic [7:0] token_char;
    logic       final_token;
  } tok_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_of_run;
    logic               stack_was_empty;
    logic               divide_by_zero_seen;
    logic               overflow_seen;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic pop;
    logic cap_a;
    logic cap_b;
    logic exec;
    logic div_step;
    logic div_fin;
    logic push;
    logic out_load;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic div_run;
    logic fin;
    logic div_last;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/pfxev_ctrl.sv
`timescale 1ns / 1ps

module pfxev_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfxev_pkg::sts_t   sts_i,
  output pfxev_pkg::cmd_t   cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_POP1    = 4'd2;
  localparam logic [3:0] S_POP2    = 4'd3;
  localparam logic [3:0] S_POP3    = 4'd4;
  localparam logic [3:0] S_EXEC    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_DIVFIN  = 4'd7;
  localparam logic [3:0] S_PUSH    = 4'd8;
  localparam logic [3:0] S_DRN_RD  = 4'd9;
  localparam logic [3:0] S_DRN_OUT = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = sts_i.is_op ? S_POP1 : S_PUSH;
      end
      S_POP1: begin
        cmd_o.pop = 1'b1;
        state_d   = S_POP2;
      end
      S_POP2: begin
        cmd_o.cap_a = 1'b1;
        cmd_o.pop   = 1'b1;
        state_d     = S_POP3;
      end
      S_POP3: begin
        cmd_o.cap_b = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.div_run ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DIVFIN;
        end
      end
      S_DIVFIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = sts_i.fin ? S_DRN_RD : S_IDLE;
      end
      S_DRN_RD: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DRN_OUT;
      end
      S_DRN_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.cnt_zero) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_DRN_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pfxev_dp.sv
`timescale 1ns / 1ps

module pfxev_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfxev_pkg::tok_t   in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output pfxev_pkg::res_t   out_data_o,
  input  pfxev_pkg::cmd_t   cmd_i,
  output pfxev_pkg::sts_t   sts_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [31:0]      mem [STACK_DEPTH];
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    cnt_m1;
  logic             full;
  logic             dz_q, ov_q;
  logic             hit_q;
  logic [31:0]      rd_q;
  pfxev_pkg::tok_t  tok_q;
  logic [31:0]      opa_q, opb_q, res_q;
  logic             out_vld_q;
  pfxev_pkg::res_t  out_q;

  logic             is_add, is_sub, is_mul, is_div, is_op;
  logic [31:0]      prod;
  logic [31:0]      digit;
  logic [31:0]      push_val;
  logic [31:0]      a_mag, b_mag;

  // restoring divider on magnitudes
  logic [31:0]      dv_rem_q, dv_quo_q, dv_den_q;
  logic             dv_neg_q;
  logic [4:0]       dv_cnt_q;
  logic [32:0]      dv_shift, dv_diff;

  assign cnt_m1 = cnt_q - CW'(1);
  assign full   = (cnt_q == CW'(STACK_DEPTH));

  assign is_add = (tok_q.token_char == pfxev_pkg::CH_ADD);
  assign is_sub = (tok_q.token_char == pfxev_pkg::CH_SUB);
  assign is_mul = (tok_q.token_char == pfxev_pkg::CH_MUL);
  assign is_div = (tok_q.token_char == pfxev_pkg::CH_DIV);
  assign is_op  = is_add | is_sub | is_mul | is_div;

  assign prod     = opa_q * opb_q;
  assign digit    = {24'd0, tok_q.token_char} - {24'd0, pfxev_pkg::CH_ZERO};
  assign push_val = is_op ? res_q : digit;
  assign a_mag    = opa_q[31] ? (32'd0 - opa_q) : opa_q;
  assign b_mag    = opb_q[31] ? (32'd0 - opb_q) : opb_q;

  assign dv_shift = {dv_rem_q, dv_quo_q[31]};
  assign dv_diff  = dv_shift - {1'b0, dv_den_q};

  assign sts_o.is_op    = is_op;
  assign sts_o.div_run  = is_div && (opb_q != 32'd0);
  assign sts_o.fin      = tok_q.final_token;
  assign sts_o.div_last = (dv_cnt_q == 5'd31);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem[cnt_q[IW-1:0]] <= push_val;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[cnt_m1[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      dz_q      <= 1'b0;
      ov_q      <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else begin
      if (cmd_i.pop) begin
        // popping an empty stack yields zero
        hit_q <= (cnt_q != '0);
        if (cnt_q != '0) begin
          cnt_q <= cnt_m1;
        end
      end
      if (cmd_i.push) begin
        if (full) begin
          ov_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
      if (cmd_i.exec && is_div && (opb_q == 32'd0)) begin
        dz_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        dv_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dv_cnt_q <= dv_cnt_q + 5'd1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
        dz_q  <= 1'b0;
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tok_q <= in_data_i;
    end
    if (cmd_i.cap_a) begin
      opa_q <= hit_q ? rd_q : 32'd0;
    end
    if (cmd_i.cap_b) begin
      opb_q <= hit_q ? rd_q : 32'd0;
    end
    if (cmd_i.exec) begin
      if (is_add) begin
        res_q <= opa_q + opb_q;
      end else if (is_sub) begin
        res_q <= opa_q - opb_q;
      end else if (is_mul) begin
        res_q <= prod;
      end else begin
        res_q <= 32'd0;
      end
      dv_rem_q <= 32'd0;
      dv_quo_q <= a_mag;
      dv_den_q <= b_mag;
      dv_neg_q <= opa_q[31] ^ opb_q[31];
    end
    if (cmd_i.div_step) begin
      if (!dv_diff[32]) begin
        dv_rem_q <= dv_diff[31:0];
        dv_quo_q <= {dv_quo_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= dv_shift[31:0];
        dv_quo_q <= {dv_quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.div_fin) begin
      res_q <= dv_neg_q ? (32'd0 - dv_quo_q) : dv_quo_q;
    end
    if (cmd_i.out_load) begin
      out_q.value               <= hit_q ? rd_q : 32'd0;
      out_q.last_of_run         <= (cnt_q == '0);
      out_q.stack_was_empty     <= !hit_q;
      out_q.divide_by_zero_seen <= dz_q;
      out_q.overflow_seen       <= ov_q;
    end
  end

endmodule

// File: rtl/prefix_expression_evaluator.sv
`timescale 1ns / 1ps

// Channel  Signals                          Beat
// in       in_valid_i/in_ready_o/in_data_i    one character, last character first
// out      out_valid_o/out_ready_i/out_data_o one drained stack value, top first
//
// Digit or other push: load, dispatch, push. + - *: load, dispatch, two pops,
// operand captures, execute, push. /: the same through the 32-step restoring
// divider; a zero divisor skips the divider. Each drained value takes a stack
// memory read, then an output register load. One item is worked on at a time.
// rst_ni clears the stack count and sticky flags; no clearing pass is needed.
// A stalled output holds the drain; the output register lets the final beat
// wait while the next character is taken.

module prefix_expression_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfxev_pkg::tok_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfxev_pkg::res_t   out_data_o
);

  pfxev_pkg::cmd_t cmd;
  pfxev_pkg::sts_t sts;

  pfxev_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfxev_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// File: rtl/prefix_expression_evaluator_chk.sv
`timescale 1ns / 1ps
`include "prefix_expression_evaluator_macros.svh"

module prefix_expression_evaluator_chk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pfxev_pkg::tok_t   in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pfxev_pkg::res_t   out_data_i
);

  `PFXEV_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_i, in_valid_i && $stable(in_data_i))
  `PFXEV_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  `PFXEV_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i)
  `PFXEV_ASSERT_NOW(a_empty_beat, out_valid_i && out_data_i.stack_was_empty, out_data_i.last_of_run && (out_data_i.value == 32'sd0))

endmodule

bind prefix_expression_evaluator prefix_expression_evaluator_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

// File: test/prefix_eval_checker.sv
`timescale 1ns / 1ps

module prefix_eval_checker #(
  parameter int DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pfxev_pkg::tok_t   in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pfxev_pkg::res_t   out_data_i,
  output int                errors_o,
  output int                pending_o
);
  import pfxev_pkg::*;

  logic [31:0] eval_stack [DEPTH];
  int          stack_used;
  logic        dz_sticky;
  logic        ovf_sticky;
  res_t        drain_q [$];
  int          mismatches;

  function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  task automatic push_val(input logic [31:0] v);
    if (stack_used >= DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      eval_stack[stack_used] = v;
      stack_used++;
    end
  endtask

  task automatic pop_val(output logic [31:0] v);
    if (stack_used == 0) begin
      v = '0;
    end else begin
      stack_used--;
      v = eval_stack[stack_used];
    end
  endtask

  // Apply one character to the model stack; a final character queues the drain.
  task automatic apply_token(input tok_t t);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    res_t        e;
    case (t.token_char)
      CH_ADD, CH_SUB, CH_MUL, CH_DIV: begin
        pop_val(a);
        pop_val(b);
        case (t.token_char)
          CH_ADD: r = a + b;
          CH_SUB: r = a - b;
          CH_MUL: r = a * b;
          default: begin
            if (b == '0) begin
              r = '0;
              dz_sticky = 1'b1;
            end else begin
              r = trunc_quot(a, b);
            end
          end
        endcase
        push_val(r);
      end
      default: push_val({24'd0, t.token_char} - {24'd0, CH_ZERO});
    endcase
    if (!t.final_token) return;
    e.divide_by_zero_seen = dz_sticky;
    e.overflow_seen       = ovf_sticky;
    if (stack_used == 0) begin
      e.value           = '0;
      e.last_of_run     = 1'b1;
      e.stack_was_empty = 1'b1;
      drain_q.push_back(e);
    end else begin
      e.stack_was_empty = 1'b0;
      while (stack_used > 0) begin
        pop_val(r);
        e.value       = r;
        e.last_of_run = (stack_used == 0);
        drain_q.push_back(e);
      end
    end
    stack_used = 0;
    dz_sticky  = 1'b0;
    ovf_sticky = 1'b0;
  endtask

  task automatic report(input string fld, input longint exp_v, input longint got_v);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, fld, exp_v, got_v);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      stack_used = 0;
      dz_sticky  = 1'b0;
      ovf_sticky = 1'b0;
      mismatches = 0;
      drain_q.delete();
    end else begin
      // an output beat can never stem from the input beat of the same edge
      if (out_valid_i && out_ready_i) begin
        if (drain_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none got value %0d last %b",
                   $time, $signed(out_data_i.value), out_data_i.last_of_run);
          mismatches++;
        end else begin
          e = drain_q.pop_front();
          if (out_data_i.value !== e.value)
            report("value", $signed(e.value), $signed(out_data_i.value));
          if (out_data_i.last_of_run !== e.last_of_run)
            report("last_of_run", e.last_of_run, out_data_i.last_of_run);
          if (out_data_i.stack_was_empty !== e.stack_was_empty)
            report("stack_was_empty", e.stack_was_empty, out_data_i.stack_was_empty);
          if (out_data_i.divide_by_zero_seen !== e.divide_by_zero_seen)
            report("divide_by_zero_seen", e.divide_by_zero_seen,
                   out_data_i.divide_by_zero_seen);
          if (out_data_i.overflow_seen !== e.overflow_seen)
            report("overflow_seen", e.overflow_seen, out_data_i.overflow_seen);
        end
      end
      if (in_valid_i && in_ready_i) apply_token(in_data_i);
    end
    errors_o  <= mismatches;
    pending_o <= drain_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import pfxev_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int LIMIT       = 500000;
  localparam int RAND_ITEMS  = 260;
  localparam logic [7:0] OPS [4] = '{CH_ADD, CH_SUB, CH_MUL, CH_DIV};

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  tok_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_data_o;

  int errors;
  int pending;
  int sent;
  int cycles;
  int floods;
  bit calm;
  bit drained_once;

  prefix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  prefix_eval_checker #(.DEPTH(STACK_DEPTH)) chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_op(input logic [7:0] ch);
    return ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV;
  endfunction

  function automatic logic [7:0] pick_operand();
    logic [7:0] ch;
    if ($urandom_range(0, 4) != 0) return CH_ZERO + 8'($urandom_range(0, 9));
    do ch = 8'($urandom_range(0, 255)); while (is_op(ch));
    return ch;
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  // valid is only lowered when a gap follows, so back-to-back beats keep it high
  task automatic send_tok(input logic [7:0] ch, input bit fin);
    int gap;
    tok_t t;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_len();
    t.token_char  = ch;
    t.final_token = fin;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // drop valid so the accepted beat is not taken again, then let every result out
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  // Characters in arrival order; a broken one has a random operator count.
  task automatic send_expr(input bit broken);
    int pushes_left;
    int ops_left;
    int depth;
    bit fin;
    pushes_left = $urandom_range(1, 8);
    ops_left    = broken ? $urandom_range(0, pushes_left + 1) : pushes_left - 1;
    depth       = 0;
    while (pushes_left + ops_left > 0) begin
      fin = (pushes_left + ops_left == 1);
      if (pushes_left > 0 && (ops_left == 0 || depth < 2 || $urandom_range(0, 1) == 1)) begin
        pushes_left--;
        depth++;
        send_tok(pick_operand(), fin);
      end else begin
        ops_left--;
        depth = (depth > 0) ? depth - 1 : 0;
        send_tok(OPS[$urandom_range(0, 3)], fin);
      end
    end
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++)
      send_tok(8'($urandom_range(0, 255)), i == len - 1 || $urandom_range(0, 15) == 0);
  endtask

  // Push STACK_DEPTH - 2 to STACK_DEPTH + 8 operands so pushes can get dropped, then drain the stack.
  task automatic send_flood();
    int len;
    len = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 8);
    for (int i = 0; i < len; i++)
      send_tok(pick_operand(), i == len - 1);
  endtask

  initial begin
    int kind;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    sent         = 0;
    floods       = 0;
    calm         = 1'b0;
    drained_once = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // operator on an empty stack pops zeros
    send_tok(CH_ADD, 1'b1);
    // field extremes: 207 * -48
    send_tok(8'h00, 1'b0);
    send_tok(8'hFF, 1'b0);
    send_tok(CH_MUL, 1'b1);
    send_tok(CH_ZERO + 8'd4, 1'b0);
    send_tok(CH_ZERO + 8'd3, 1'b0);
    send_tok(CH_ADD, 1'b1);
    send_tok(CH_ZERO + 8'd2, 1'b0);
    send_tok(CH_ZERO + 8'd9, 1'b0);
    send_tok(CH_SUB, 1'b1);
    // divide by zero
    send_tok(CH_ZERO, 1'b0);
    send_tok(CH_ZERO + 8'd7, 1'b0);
    send_tok(CH_DIV, 1'b1);
    // -1 below, then 128^4 * 8 wraps to the most negative value, then divide
    send_tok(CH_ZERO + 8'd1, 1'b0);
    send_tok(CH_ZERO, 1'b0);
    send_tok(CH_SUB, 1'b0);
    repeat (4) send_tok(CH_ZERO + 8'd128, 1'b0);
    repeat (3) send_tok(CH_MUL, 1'b0);
    send_tok(CH_ZERO + 8'd8, 1'b0);
    send_tok(CH_MUL, 1'b0);
    send_tok(CH_DIV, 1'b1);

    hold_until_drained();
    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 13) send_expr(1'b0);
      else if (kind < 16) send_expr(1'b1);
      else if (kind < 19 || floods >= 3) send_noise();
      else begin
        send_flood();
        floods++;
      end
      if (!drained_once && sent >= RAND_ITEMS / 2) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
